[src/kvb_pkg.sv]
// kvb_pkg: shared widths, item and entry types, and the quantized normal table
// for the keyframe vertex blender. No dependencies.
`timescale 1ns / 1ps

package kvb_pkg;

   localparam int IDX_W  = 11;
   localparam int POS_W  = 24;
   localparam int NRM_W  = 16;
   localparam int FRAC_W = 16;
   localparam int TW_W   = 17;
   localparam int CODE_W = 8;

   localparam int DEF_MAX_VERTICES  = 2048;
   localparam int NORMAL_TABLE_SIZE = 162;
   localparam logic [TW_W-1:0] TW_ONE = TW_W'(65536);

   localparam int WORK_QUEUE_DEPTH = 4;
   localparam int RESULT_QUEUE_DEPTH = 2;

   typedef enum logic {
      FUNC_CLEAR = 1'b0,
      FUNC_BLEND = 1'b1
   } func_type;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [NRM_W-1:0] nrm_type;
   typedef nrm_type [2:0] nvec_type;

   // one classified item between front and back
   typedef struct packed {
      logic              clear;
      logic [IDX_W-1:0]  vtx;
      logic [IDX_W-1:0]  quo;
      pos_type [2:0]     ka;
      pos_type [2:0]     kb;
      nrm_type [2:0]     na;
      nrm_type [2:0]     nb;
      logic [FRAC_W-1:0] frac;
      logic [TW_W-1:0]   tw;
   } work_type;

   typedef struct packed {
      pos_type [2:0] pos;
      nrm_type [2:0] nrm;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] vtx;
      entry_type        ent;
   } result_type;

   localparam int N_A = 8614;
   localparam int N_B = 13937;
   localparam int N_C = 7256;
   localparam int N_D = 3913;
   localparam int N_E = 14159;
   localparam int N_F = 4837;
   localparam int N_G = 15654;
   localparam int N_H = 5063;
   localparam int N_I = 8192;
   localparam int N_J = 13255;
   localparam int N_K = 2662;
   localparam int N_L = 4307;
   localparam int N_M = 15582;
   localparam int N_O = 16384;
   localparam int N_P = 2419;
   localparam int N_Q = 11740;
   localparam int N_R = 11169;
   localparam int N_S = 9630;
   localparam int N_T = 6969;
   localparam int N_U = 11275;

   // unit directions in Q1.14, x y z
   localparam int NORMAL_DIRS [NORMAL_TABLE_SIZE][3] = '{
      '{-N_A,0,N_B},'{-N_C,N_D,N_E},'{-N_F,0,N_G},'{-N_H,N_I,N_J},'{-N_K,N_L,N_M},
      '{0,0,N_O},'{0,N_B,N_A},'{-N_P,N_Q,N_R},'{N_P,N_Q,N_R},'{0,N_A,N_B},
      '{N_H,N_I,N_J},'{N_A,0,N_B},'{N_F,0,N_G},'{N_C,N_D,N_E},'{N_K,N_L,N_M},
      '{-N_R,N_P,N_Q},'{-N_J,N_H,N_I},'{-N_S,N_T,N_U},'{-N_B,N_A,0},'{-N_E,N_C,N_D},
      '{-N_Q,N_R,N_P},'{-N_U,N_S,N_T},'{-N_I,N_J,N_H},'{-N_D,N_E,N_C},'{-N_T,N_U,N_S},
      '{-N_Q,N_R,-N_P},'{-N_I,N_J,-N_H},'{-N_A,N_B,0},'{0,N_B,-N_A},'{-N_D,N_E,-N_C},
      '{0,N_G,-N_F},'{-N_L,N_M,-N_K},'{0,N_O,0},'{0,N_G,N_F},'{-N_L,N_M,N_K},
      '{N_D,N_E,N_C},'{N_L,N_M,N_K},'{N_I,N_J,N_H},'{N_D,N_E,-N_C},'{N_L,N_M,-N_K},
      '{N_I,N_J,-N_H},'{N_B,N_A,0},'{N_Q,N_R,N_P},'{N_Q,N_R,-N_P},'{N_A,N_B,0},
      '{N_T,N_U,N_S},'{N_E,N_C,N_D},'{N_U,N_S,N_T},'{N_J,N_H,N_I},'{N_R,N_P,N_Q},
      '{N_S,N_T,N_U},'{N_G,N_F,0},'{N_O,0,0},'{N_M,N_K,N_L},'{N_B,-N_A,0},
      '{N_G,-N_F,0},'{N_E,-N_C,N_D},'{N_M,-N_K,N_L},'{N_J,-N_H,N_I},'{N_R,-N_P,N_Q},
      '{N_B,0,N_A},'{N_E,N_C,-N_D},'{N_J,N_H,-N_I},'{N_M,N_K,-N_L},'{N_A,0,-N_B},
      '{N_R,N_P,-N_Q},'{N_R,-N_P,-N_Q},'{N_B,0,-N_A},'{N_J,-N_H,-N_I},'{N_E,-N_C,-N_D},
      '{N_M,-N_K,-N_L},'{N_P,N_Q,-N_R},'{N_H,N_I,-N_J},'{N_T,N_U,-N_S},'{N_C,N_D,-N_E},
      '{N_S,N_T,-N_U},'{N_U,N_S,-N_T},'{-N_P,N_Q,-N_R},'{-N_H,N_I,-N_J},'{0,N_A,-N_B},
      '{-N_A,0,-N_B},'{-N_C,N_D,-N_E},'{-N_F,0,-N_G},'{-N_K,N_L,-N_M},'{0,0,-N_O},
      '{N_F,0,-N_G},'{N_K,N_L,-N_M},'{-N_C,-N_D,-N_E},'{-N_H,-N_I,-N_J},'{-N_K,-N_L,-N_M},
      '{0,-N_B,-N_A},'{-N_P,-N_Q,-N_R},'{N_P,-N_Q,-N_R},'{0,-N_A,-N_B},'{N_H,-N_I,-N_J},
      '{N_C,-N_D,-N_E},'{N_K,-N_L,-N_M},'{N_D,-N_E,-N_C},'{N_I,-N_J,-N_H},'{N_T,-N_U,-N_S},
      '{N_Q,-N_R,-N_P},'{N_U,-N_S,-N_T},'{N_S,-N_T,-N_U},'{0,-N_G,-N_F},'{0,-N_O,0},
      '{N_L,-N_M,-N_K},'{0,-N_B,N_A},'{0,-N_G,N_F},'{N_D,-N_E,N_C},'{N_L,-N_M,N_K},
      '{N_I,-N_J,N_H},'{N_Q,-N_R,N_P},'{N_A,-N_B,0},'{-N_D,-N_E,-N_C},'{-N_I,-N_J,-N_H},
      '{-N_L,-N_M,-N_K},'{-N_B,-N_A,0},'{-N_Q,-N_R,-N_P},'{-N_Q,-N_R,N_P},'{-N_A,-N_B,0},
      '{-N_I,-N_J,N_H},'{-N_D,-N_E,N_C},'{-N_L,-N_M,N_K},'{-N_E,-N_C,N_D},'{-N_J,-N_H,N_I},
      '{-N_U,-N_S,N_T},'{-N_R,-N_P,N_Q},'{-N_C,-N_D,N_E},'{-N_S,-N_T,N_U},'{-N_H,-N_I,N_J},
      '{-N_P,-N_Q,N_R},'{-N_T,-N_U,N_S},'{-N_K,-N_L,N_M},'{N_C,-N_D,N_E},'{N_K,-N_L,N_M},
      '{N_H,-N_I,N_J},'{N_P,-N_Q,N_R},'{0,-N_A,N_B},'{N_T,-N_U,N_S},'{N_S,-N_T,N_U},
      '{N_U,-N_S,N_T},'{-N_G,N_F,0},'{-N_M,N_K,N_L},'{-N_O,0,0},'{-N_B,0,N_A},
      '{-N_G,-N_F,0},'{-N_M,-N_K,N_L},'{-N_E,N_C,-N_D},'{-N_M,N_K,-N_L},'{-N_J,N_H,-N_I},
      '{-N_E,-N_C,-N_D},'{-N_M,-N_K,-N_L},'{-N_J,-N_H,-N_I},'{-N_R,N_P,-N_Q},'{-N_R,-N_P,-N_Q},
      '{-N_B,0,-N_A},'{-N_U,N_S,-N_T},'{-N_S,N_T,-N_U},'{-N_T,N_U,-N_S},'{-N_T,-N_U,-N_S},
      '{-N_S,-N_T,-N_U},'{-N_U,-N_S,-N_T}
   };

   // codes past the table give the zero vector
   function automatic nvec_type normal_dir(input logic [CODE_W-1:0] code);
      nvec_type v;
      v = '0;
      if (code < CODE_W'(NORMAL_TABLE_SIZE)) begin
         for (int k = 0; k < 3; k++) begin
            v[k] = NRM_W'(NORMAL_DIRS[code][k]);
         end
      end
      return v;
   endfunction

endpackage

[src/kvb_queue.sv]
// kvb_queue: small register FIFO used between front and back and on the results.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module kvb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[src/kvb_front.sv]
// kvb_front: classifies an incoming item: clear or blend, normal table lookup,
// weight saturation, and the quotient for the index reduction. Uses kvb_pkg.
`timescale 1ns / 1ps

module kvb_front import kvb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic              func,
   input  logic [IDX_W-1:0]  vertex_index,
   input  pos_type           key_a_x,
   input  pos_type           key_a_y,
   input  pos_type           key_a_z,
   input  pos_type           key_b_x,
   input  pos_type           key_b_y,
   input  pos_type           key_b_z,
   input  logic [CODE_W-1:0] normal_a_code,
   input  logic [CODE_W-1:0] normal_b_code,
   input  logic [FRAC_W-1:0] frame_fraction,
   input  logic [TW_W-1:0]   tween_weight,
   output work_type          item
);

   localparam int RECIP_SH = 2 * IDX_W;

   logic [IDX_W-1:0] quo;

   // index reduction: quotient by reciprocal here, remainder in the back end
   if (MAX_VERTICES < (1 << IDX_W)) begin : g_reduce
      localparam int Recip = (1 << RECIP_SH) / MAX_VERTICES;
      logic [RECIP_SH+IDX_W-1:0] prod;
      assign prod = (RECIP_SH+IDX_W)'(vertex_index) * (RECIP_SH+IDX_W)'(Recip);
      assign quo  = prod[RECIP_SH +: IDX_W];
   end else begin : g_plain
      assign quo = '0;
   end

   always_comb begin
      item.clear = (func_type'(func) == FUNC_CLEAR);
      item.vtx   = vertex_index;
      item.quo   = quo;
      item.ka    = {key_a_z, key_a_y, key_a_x};
      item.kb    = {key_b_z, key_b_y, key_b_x};
      item.na    = normal_dir(normal_a_code);
      item.nb    = normal_dir(normal_b_code);
      item.frac  = frame_fraction;
      item.tw    = (tween_weight > TW_ONE) ? TW_ONE : tween_weight;
   end

endmodule

[src/kvb_back.sv]
// kvb_back: blend pipeline with the working vertex store. Reads the entry,
// forms the target, moves the entry toward it (or zeroes it for a clear) and writes it back. Uses kvb_pkg.
`timescale 1ns / 1ps

module kvb_back import kvb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic       clock,
   input  logic       reset,
   input  work_type   item,
   input  logic       item_valid,
   output logic       item_pop,
   output result_type res,
   output logic       res_push,
   input  logic       res_full
);

   localparam int IW   = $clog2(MAX_VERTICES);
   localparam int PP_W = POS_W + 1 + FRAC_W + 1;
   localparam int NP_W = NRM_W + 1 + FRAC_W + 1;
   localparam int PQ_W = POS_W + 1 + TW_W + 1;
   localparam int NQ_W = NRM_W + 1 + TW_W + 1;

   // working store
   entry_type mem [MAX_VERTICES];
   entry_type rdata_ff;
   logic [IW-1:0] raddr;

   // stage 0 (queue head)
   logic [IW-1:0]    idx0;
   logic [IDX_W-1:0] vout0;
   logic signed [PP_W-1:0] pp0 [3];
   logic signed [NP_W-1:0] np0 [3];

   // stage 1
   logic             b1_v_ff, b1_v_in;
   logic             b1_clear_ff;
   logic [IW-1:0]    b1_idx_ff;
   logic [IDX_W-1:0] b1_vout_ff;
   pos_type          b1_ka_ff [3];
   nrm_type          b1_na_ff [3];
   logic signed [PP_W-1:0] b1_pp_ff [3];
   logic signed [NP_W-1:0] b1_np_ff [3];
   logic [TW_W-1:0]  b1_tw_ff;

   // stage 2
   logic             b2_v_ff, b2_v_in;
   logic             b2_clear_ff;
   logic [IW-1:0]    b2_idx_ff;
   logic [IDX_W-1:0] b2_vout_ff;
   entry_type        b2_old_ff;
   logic signed [POS_W:0] b2_dp_ff [3];
   logic signed [NRM_W:0] b2_dn_ff [3];
   logic [TW_W-1:0]  b2_tw_ff;

   // stage 3
   logic             b3_v_ff, b3_v_in;
   logic             b3_clear_ff;
   logic [IW-1:0]    b3_idx_ff;
   logic [IDX_W-1:0] b3_vout_ff;
   entry_type        b3_old_ff;
   logic signed [PQ_W-1:0] b3_pq_ff [3];
   logic signed [NQ_W-1:0] b3_nq_ff [3];

   // last write, for the read that missed it
   logic             lw_v_ff, lw_v_in;
   logic [IW-1:0]    lw_idx_ff;
   entry_type        lw_data_ff;

   logic      go, hazard, b1_adv, b1_take, we;
   entry_type old1, new3;
   logic signed [POS_W:0] dp1 [3];
   logic signed [NRM_W:0] dn1 [3];
   logic signed [PQ_W-1:0] pq2 [3];
   logic signed [NQ_W-1:0] nq2 [3];

   if (MAX_VERTICES < (1 << IDX_W)) begin : g_mod
      logic [2*IDX_W-1:0] qm;
      logic [IDX_W-1:0]   r0, r1;
      assign qm    = (2*IDX_W)'(item.quo) * (2*IDX_W)'(MAX_VERTICES);
      assign r0    = item.vtx - qm[IDX_W-1:0];
      assign r1    = (r0 >= IDX_W'(MAX_VERTICES)) ? r0 - IDX_W'(MAX_VERTICES) : r0;
      assign idx0  = r1[IW-1:0];
      assign vout0 = r1;
   end else begin : g_nomod
      assign idx0  = IW'(item.vtx);
      assign vout0 = item.vtx;
   end

   // the item just ahead has no new value yet: hold stage 1
   assign go       = !res_full;
   assign hazard   = b1_v_ff && b2_v_ff && (b2_idx_ff == b1_idx_ff);
   assign b1_adv   = b1_v_ff && !hazard && go;
   assign b1_take  = go && (!b1_v_ff || b1_adv);
   assign item_pop = item_valid && b1_take;
   assign raddr    = item_pop ? idx0 : b1_idx_ff;
   assign we       = b3_v_ff && go;

   assign b1_v_in = b1_take ? item_valid : b1_v_ff;
   assign b2_v_in = go ? b1_adv : b2_v_ff;
   assign b3_v_in = go ? b2_v_ff : b3_v_ff;
   assign lw_v_in = we;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pp0[k] = PP_W'(POS_W'(item.kb[k])) - PP_W'(POS_W'(item.ka[k]));
         pp0[k] = pp0[k] * $signed(PP_W'(item.frac));
         np0[k] = NP_W'(item.nb[k]) - NP_W'(item.na[k]);
         np0[k] = np0[k] * $signed(NP_W'(item.frac));
      end
   end

   // stage 3 result, also forwarded to stage 1
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (b3_clear_ff) begin
            new3.pos[k] = '0;
            new3.nrm[k] = '0;
         end else begin
            new3.pos[k] = b3_old_ff.pos[k] + POS_W'(b3_pq_ff[k] >>> 16);
            new3.nrm[k] = b3_old_ff.nrm[k] + NRM_W'(b3_nq_ff[k] >>> 16);
         end
      end
   end

   always_comb begin
      if (b3_v_ff && b3_idx_ff == b1_idx_ff) begin
         old1 = new3;
      end else if (lw_v_ff && lw_idx_ff == b1_idx_ff) begin
         old1 = lw_data_ff;
      end else begin
         old1 = rdata_ff;
      end
      for (int k = 0; k < 3; k++) begin
         dp1[k] = (POS_W+1)'(b1_ka_ff[k]) + (POS_W+1)'(b1_pp_ff[k] >>> 16)
                  - (POS_W+1)'(old1.pos[k]);
         dn1[k] = (NRM_W+1)'(b1_na_ff[k]) + (NRM_W+1)'(b1_np_ff[k] >>> 16)
                  - (NRM_W+1)'(old1.nrm[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pq2[k] = PQ_W'(b2_dp_ff[k]) * $signed(PQ_W'(b2_tw_ff));
         nq2[k] = NQ_W'(b2_dn_ff[k]) * $signed(NQ_W'(b2_tw_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         lw_v_ff <= 1'b0;
      end else begin
         b1_v_ff <= b1_v_in;
         b2_v_ff <= b2_v_in;
         b3_v_ff <= b3_v_in;
         lw_v_ff <= lw_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         b1_clear_ff <= item.clear;
         b1_idx_ff   <= idx0;
         b1_vout_ff  <= vout0;
         b1_tw_ff    <= item.tw;
         for (int k = 0; k < 3; k++) begin
            b1_ka_ff[k] <= item.ka[k];
            b1_na_ff[k] <= item.na[k];
            b1_pp_ff[k] <= pp0[k];
            b1_np_ff[k] <= np0[k];
         end
      end
      if (go) begin
         b2_clear_ff <= b1_clear_ff;
         b2_idx_ff   <= b1_idx_ff;
         b2_vout_ff  <= b1_vout_ff;
         b2_old_ff   <= old1;
         b2_tw_ff    <= b1_tw_ff;
         b2_dp_ff    <= dp1;
         b2_dn_ff    <= dn1;
         b3_clear_ff <= b2_clear_ff;
         b3_idx_ff   <= b2_idx_ff;
         b3_vout_ff  <= b2_vout_ff;
         b3_old_ff   <= b2_old_ff;
         b3_pq_ff    <= pq2;
         b3_nq_ff    <= nq2;
      end
      lw_idx_ff  <= b3_idx_ff;
      lw_data_ff <= new3;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[b3_idx_ff] <= new3;
      end
      rdata_ff <= mem[raddr];
   end

   assign res_push = we;
   assign res.vtx  = b3_vout_ff;
   assign res.ent  = new3;

endmodule

[src/keyframe_vertex_blend.sv]
// Keyframe vertex blender, one result per item, queue handshakes on both
// sides. An item enters each cycle while the work queue is not full and is
// classified into a four-deep work queue; the back end reads the vertex entry
// from a single-port-write store, forms the keyframe target, moves the entry by
// the tween weight and writes it back over three pipeline stages, then a
// two-deep result queue. The sustained rate is one item per cycle while the
// result queue has room; an item that names the same vertex as the item just
// before it is held in stage 1, since that entry's new value leaves the tween
// multiplier a stage later than the next read needs it. The store needs no
// clearing after reset if the user clears an entry before it is blended; the
// block does not enforce it. Depends on kvb_pkg, kvb_front, kvb_queue, kvb_back.
`timescale 1ns / 1ps

module keyframe_vertex_blend import kvb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_func,
   input  logic [IDX_W-1:0]  req_vertex_index,
   input  pos_type           req_key_a_x,
   input  pos_type           req_key_a_y,
   input  pos_type           req_key_a_z,
   input  pos_type           req_key_b_x,
   input  pos_type           req_key_b_y,
   input  pos_type           req_key_b_z,
   input  logic [CODE_W-1:0] req_normal_a_code,
   input  logic [CODE_W-1:0] req_normal_b_code,
   input  logic [FRAC_W-1:0] req_frame_fraction,
   input  logic [TW_W-1:0]   req_tween_weight,
   output logic              empty,
   input  logic              pop,
   output logic [IDX_W-1:0]  rsp_vertex_out,
   output pos_type           rsp_pos_x,
   output pos_type           rsp_pos_y,
   output pos_type           rsp_pos_z,
   output nrm_type           rsp_norm_x,
   output nrm_type           rsp_norm_y,
   output nrm_type           rsp_norm_z
);

   work_type   front_item, head_item;
   logic       work_empty, work_pop;
   result_type back_res, out_res;
   logic       res_push, res_full;

   kvb_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .func           (req_func),
      .vertex_index   (req_vertex_index),
      .key_a_x        (req_key_a_x),
      .key_a_y        (req_key_a_y),
      .key_a_z        (req_key_a_z),
      .key_b_x        (req_key_b_x),
      .key_b_y        (req_key_b_y),
      .key_b_z        (req_key_b_z),
      .normal_a_code  (req_normal_a_code),
      .normal_b_code  (req_normal_b_code),
      .frame_fraction (req_frame_fraction),
      .tween_weight   (req_tween_weight),
      .item           (front_item)
   );

   kvb_queue #(.WIDTH($bits(work_type)), .DEPTH(WORK_QUEUE_DEPTH)) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_item),
      .full    (full),
      .rd_en   (work_pop),
      .rd_data (head_item),
      .empty   (work_empty)
   );

   kvb_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (head_item),
      .item_valid (!work_empty),
      .item_pop   (work_pop),
      .res        (back_res),
      .res_push   (res_push),
      .res_full   (res_full)
   );

   kvb_queue #(.WIDTH($bits(result_type)), .DEPTH(RESULT_QUEUE_DEPTH)) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (back_res),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (out_res),
      .empty   (empty)
   );

   assign rsp_vertex_out = out_res.vtx;
   assign rsp_pos_x      = out_res.ent.pos[0];
   assign rsp_pos_y      = out_res.ent.pos[1];
   assign rsp_pos_z      = out_res.ent.pos[2];
   assign rsp_norm_x     = out_res.ent.nrm[0];
   assign rsp_norm_y     = out_res.ent.nrm[1];
   assign rsp_norm_z     = out_res.ent.nrm[2];

endmodule

[src/kvb_checker.sv]
// kvb_checker: port-level checks on the blender's queues, bound to the top.
// Uses kvb_pkg and the ports of keyframe_vertex_blend.
`timescale 1ns / 1ps

module kvb_checker import kvb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input logic              req_func,
   input logic [IDX_W-1:0]  req_vertex_index,
   input pos_type           req_key_a_x,
   input pos_type           req_key_a_y,
   input pos_type           req_key_a_z,
   input pos_type           req_key_b_x,
   input pos_type           req_key_b_y,
   input pos_type           req_key_b_z,
   input logic [CODE_W-1:0] req_normal_a_code,
   input logic [CODE_W-1:0] req_normal_b_code,
   input logic [FRAC_W-1:0] req_frame_fraction,
   input logic [TW_W-1:0]   req_tween_weight,
   input logic              empty,
   input logic              pop,
   input logic [IDX_W-1:0]  rsp_vertex_out,
   input pos_type           rsp_pos_x,
   input pos_type           rsp_pos_y,
   input pos_type           rsp_pos_z,
   input nrm_type           rsp_norm_x,
   input nrm_type           rsp_norm_y,
   input nrm_type           rsp_norm_z
);

   // items taken in but not yet transferred out
   logic [5:0] pend_ff, pend_in;
   logic       in_xfer, out_xfer;

   assign in_xfer  = push && !full;
   assign out_xfer = pop && !empty;

   always_comb begin
      pend_in = pend_ff;
      if (in_xfer && !out_xfer) begin
         pend_in = pend_ff + 1'b1;
      end else if (out_xfer && !in_xfer) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("results visible right after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !full)
      else $error("input queue full right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == '0) |-> empty)
      else $error("result shown with no item outstanding");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_vertex_out) && $stable(rsp_pos_x)))
      else $error("waiting result changed before transfer");

endmodule

bind keyframe_vertex_blend kvb_checker u_kvb_checker (.*);
